FILE: design/bsc_pkg.sv
// Package for the button session controller.
// Holds shared widths, register defaults, command codes and the button event type.
// No dependencies.
package bsc_pkg;

  // Default width of the internal millisecond time base.
  localparam int TIME_BITS_DEF = 32;

  // Widths of the interface fields.
  localparam int TIME_MS_W = 32;
  localparam int MS16_W    = 16;
  localparam int HOLD_W    = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_BLINK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_BLINK = 3'd4;

  // Register values after reset.
  localparam logic [MS16_W-1:0] DEBOUNCE_DEF   = 16'd100;
  localparam logic [MS16_W-1:0] LONG_PRESS_DEF = 16'd800;
  localparam logic [HOLD_W-1:0] HOLDOFF_DEF    = 20'd10000;
  localparam logic [MS16_W-1:0] SLOW_BLINK_DEF = 16'd500;
  localparam logic [MS16_W-1:0] FAST_BLINK_DEF = 16'd150;

  // Session command codes.
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_SEGMENT = 2'd1;
  localparam logic [1:0] CMD_QUIT    = 2'd2;

  // Events produced by one debounced button on one poll.
  typedef struct packed {
    logic press_short;
    logic press_long;
  } btn_evt_t;

endpackage

FILE: design/bsc_button.sv
// Debouncer and short/long press detector for one active-low button.
// Depends on bsc_pkg for widths and the event type.
module bsc_button #(
  parameter int TIME_BITS = bsc_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [TIME_BITS-1:0]        now,
  input  logic                        raw,
  input  logic [bsc_pkg::MS16_W-1:0]  debounce_ms,
  input  logic [bsc_pkg::MS16_W-1:0]  long_press_ms,
  output bsc_pkg::btn_evt_t           evt
);

  logic                 stable_level, stable_level_next;
  logic                 previous_raw;
  logic [TIME_BITS-1:0] change_time, change_time_next;
  logic [TIME_BITS-1:0] press_time, press_time_next;
  logic                 long_reported, long_reported_next;
  logic [TIME_BITS-1:0] settle_age, press_age;
  logic                 settled;

  // Time since the last raw edge; the level is accepted once it is old enough.
  assign change_time_next = (raw != previous_raw) ? now : change_time;
  assign settle_age = now - change_time_next;
  assign settled = settle_age > TIME_BITS'(debounce_ms);
  assign press_age = now - press_time_next;

  // Stable-level update and press classification.
  always_comb begin
    stable_level_next  = stable_level;
    press_time_next    = press_time;
    long_reported_next = long_reported;
    evt.press_short    = 1'b0;
    evt.press_long     = 1'b0;
    if (settled) begin
      if (raw != stable_level) begin
        stable_level_next = raw;
        if (!raw) begin
          press_time_next    = now;
          long_reported_next = 1'b0;
        end else if (!long_reported) begin
          evt.press_short = 1'b1;
        end
      end
      if (!stable_level_next && !long_reported_next &&
          (press_age > TIME_BITS'(long_press_ms))) begin
        evt.press_long     = 1'b1;
        long_reported_next = 1'b1;
      end
    end
  end

  // Button state, advanced once per poll.
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level  <= 1'b1;
      previous_raw  <= 1'b1;
      change_time   <= '0;
      press_time    <= '0;
      long_reported <= 1'b0;
    end else if (step) begin
      stable_level  <= stable_level_next;
      previous_raw  <= raw;
      change_time   <= change_time_next;
      press_time    <= press_time_next;
      long_reported <= long_reported_next;
    end
  end

endmodule

FILE: design/bsc_session.sv
// Session state machine: LED blinking, pause toggle and session commands.
// Depends on bsc_pkg for widths, command codes and the button event type.
module bsc_session #(
  parameter int TIME_BITS = bsc_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [TIME_BITS-1:0]        now,
  input  bsc_pkg::btn_evt_t           start_evt,
  input  bsc_pkg::btn_evt_t           create_evt,
  input  bsc_pkg::btn_evt_t           finish_evt,
  input  logic [bsc_pkg::HOLD_W-1:0]  restart_holdoff_ms,
  input  logic [bsc_pkg::MS16_W-1:0]  slow_blink_ms,
  input  logic [bsc_pkg::MS16_W-1:0]  fast_blink_ms,
  output logic                        led_on,
  output logic                        pause_toggle_sent,
  output logic                        command_valid,
  output logic [1:0]                  command_code,
  output logic [1:0]                  session_state
);

  // Compare width wide enough for both the time base and the holdoff register.
  localparam int CW = (TIME_BITS > bsc_pkg::HOLD_W) ? TIME_BITS : bsc_pkg::HOLD_W;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_REC      = 2'd1,
    ST_CREATED  = 2'd2,
    ST_FINISHED = 2'd3
  } mode_t;

  mode_t                mode_now, mode_now_next;
  logic                 blink_phase, blink_phase_next;
  logic                 led_pin, led_pin_next;
  logic                 fast_mode, fast_mode_next;
  logic [TIME_BITS-1:0] blink_time, blink_time_next;
  logic [TIME_BITS-1:0] created_time, created_time_next;
  logic                 restart_allowed, restart_allowed_next;
  logic                 start_short;
  logic [TIME_BITS-1:0] blink_age, created_age;
  logic [bsc_pkg::MS16_W-1:0] interval;

  assign blink_age   = now - blink_time;
  assign created_age = now - created_time;

  // Next session state and this poll's commands.
  always_comb begin
    mode_now_next        = mode_now;
    blink_phase_next     = blink_phase;
    led_pin_next         = led_pin;
    fast_mode_next       = fast_mode;
    blink_time_next      = blink_time;
    created_time_next    = created_time;
    restart_allowed_next = restart_allowed;
    pause_toggle_sent    = 1'b0;
    command_valid        = 1'b0;
    command_code         = bsc_pkg::CMD_START;
    start_short          = start_evt.press_short;

    // A long start press while recording toggles pause and eats the short press.
    if (start_evt.press_long && (mode_now == ST_REC)) begin
      fast_mode_next    = ~fast_mode;
      pause_toggle_sent = 1'b1;
      start_short       = 1'b0;
    end

    // The blink interval follows the mode as it stands after a pause toggle.
    interval = fast_mode_next ? fast_blink_ms : slow_blink_ms;

    unique case (mode_now)
      ST_IDLE: begin
        led_pin_next = 1'b1;
        if (start_short) begin
          mode_now_next = ST_REC;
          command_valid = 1'b1;
          command_code  = bsc_pkg::CMD_START;
        end
      end
      ST_REC: begin
        if (blink_age > TIME_BITS'(interval)) begin
          blink_phase_next = ~blink_phase;
          led_pin_next     = ~blink_phase;
          blink_time_next  = now;
        end
        if (finish_evt.press_short) begin
          mode_now_next = ST_FINISHED;
          command_valid = 1'b1;
          command_code  = bsc_pkg::CMD_QUIT;
        end else if (create_evt.press_short) begin
          mode_now_next     = ST_CREATED;
          command_valid     = 1'b1;
          command_code      = bsc_pkg::CMD_SEGMENT;
          created_time_next = now;
        end
      end
      ST_CREATED: begin
        led_pin_next   = 1'b1;
        fast_mode_next = 1'b0;
        if (!restart_allowed && (CW'(created_age) > CW'(restart_holdoff_ms))) begin
          restart_allowed_next = 1'b1;
        end
        if (finish_evt.press_short) begin
          mode_now_next = ST_FINISHED;
          command_valid = 1'b1;
          command_code  = bsc_pkg::CMD_QUIT;
        end else if (start_short && restart_allowed_next) begin
          mode_now_next        = ST_REC;
          restart_allowed_next = 1'b0;
          command_valid        = 1'b1;
          command_code         = bsc_pkg::CMD_START;
        end
      end
      default: begin
        led_pin_next = 1'b0;
      end
    endcase

    led_on        = led_pin_next;
    session_state = mode_now_next;
  end

  // Session registers, advanced once per poll.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_now        <= ST_IDLE;
      blink_phase     <= 1'b0;
      led_pin         <= 1'b0;
      fast_mode       <= 1'b0;
      blink_time      <= '0;
      created_time    <= '0;
      restart_allowed <= 1'b0;
    end else if (step) begin
      mode_now        <= mode_now_next;
      blink_phase     <= blink_phase_next;
      led_pin         <= led_pin_next;
      fast_mode       <= fast_mode_next;
      blink_time      <= blink_time_next;
      created_time    <= created_time_next;
      restart_allowed <= restart_allowed_next;
    end
  end

endmodule

FILE: design/button_session_controller_top.sv
// Top level of the button session controller: stream ports, configuration
// registers, poll input register and result register. Uses bsc_pkg, bsc_button, bsc_session.
// A poll is taken into the poll input register and then moves on into the result register,
// from which its result transaction is offered downstream.
// Throughput: one poll per cycle; the poll register and the result register stall
// only when the result register is full and the downstream side holds off.
// Reset (rst, synchronous) empties both registers, restores the register defaults,
// releases all buttons and returns the session to idle with the LED off.
module button_session_controller_top #(
  parameter int TIME_BITS = bsc_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input polls.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: time_ms[31:0], start_level, create_level, finish_level, zero pad.
  input  logic [bsc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Poll results.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0: led_on, pause_toggle_sent, command_valid, command_code[1:0],
  // session_state[1:0], zero pad.
  output logic [bsc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [bsc_pkg::MS16_W-1:0]    debounce_ms, long_press_ms, slow_blink_ms, fast_blink_ms;
  logic [bsc_pkg::HOLD_W-1:0]    restart_holdoff_ms;
  logic                          poll_valid;
  logic [bsc_pkg::TIME_MS_W-1:0] poll_time;
  logic [2:0]                    poll_levels;
  logic                          advance, step;
  logic [TIME_BITS-1:0]          now;
  bsc_pkg::btn_evt_t             start_evt, create_evt, finish_evt;
  logic                          led_on, pause_toggle_sent, command_valid;
  logic [1:0]                    command_code, session_state;
  logic                          out_valid;
  logic [bsc_pkg::OUT_TDATA_W-1:0] out_data;

  // Configuration registers; out-of-range indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms        <= bsc_pkg::DEBOUNCE_DEF;
      long_press_ms      <= bsc_pkg::LONG_PRESS_DEF;
      restart_holdoff_ms <= bsc_pkg::HOLDOFF_DEF;
      slow_blink_ms      <= bsc_pkg::SLOW_BLINK_DEF;
      fast_blink_ms      <= bsc_pkg::FAST_BLINK_DEF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsc_pkg::REG_DEBOUNCE:   debounce_ms        <= cfg_data[bsc_pkg::MS16_W-1:0];
        bsc_pkg::REG_LONG_PRESS: long_press_ms      <= cfg_data[bsc_pkg::MS16_W-1:0];
        bsc_pkg::REG_HOLDOFF:    restart_holdoff_ms <= cfg_data[bsc_pkg::HOLD_W-1:0];
        bsc_pkg::REG_SLOW_BLINK: slow_blink_ms      <= cfg_data[bsc_pkg::MS16_W-1:0];
        bsc_pkg::REG_FAST_BLINK: fast_blink_ms      <= cfg_data[bsc_pkg::MS16_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow: the poll register moves on whenever the result register can load.
  assign advance       = !out_valid || m_axis_tready;
  assign step          = poll_valid && advance;
  assign s_axis_tready = !poll_valid || advance;

  // Poll input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (s_axis_tready) begin
      poll_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      poll_time   <= s_axis_tdata[bsc_pkg::TIME_MS_W-1:0];
      poll_levels <= s_axis_tdata[bsc_pkg::TIME_MS_W+2:bsc_pkg::TIME_MS_W];
    end
  end

  // Timestamp reduced or widened to the internal time base.
  assign now = TIME_BITS'(poll_time);

  bsc_button #(.TIME_BITS(TIME_BITS)) u_start (
    .clk(clk), .rst(rst), .step(step), .now(now), .raw(poll_levels[0]),
    .debounce_ms(debounce_ms), .long_press_ms(long_press_ms), .evt(start_evt)
  );

  bsc_button #(.TIME_BITS(TIME_BITS)) u_create (
    .clk(clk), .rst(rst), .step(step), .now(now), .raw(poll_levels[1]),
    .debounce_ms(debounce_ms), .long_press_ms(long_press_ms), .evt(create_evt)
  );

  bsc_button #(.TIME_BITS(TIME_BITS)) u_finish (
    .clk(clk), .rst(rst), .step(step), .now(now), .raw(poll_levels[2]),
    .debounce_ms(debounce_ms), .long_press_ms(long_press_ms), .evt(finish_evt)
  );

  bsc_session #(.TIME_BITS(TIME_BITS)) u_session (
    .clk(clk), .rst(rst), .step(step), .now(now),
    .start_evt(start_evt), .create_evt(create_evt), .finish_evt(finish_evt),
    .restart_holdoff_ms(restart_holdoff_ms),
    .slow_blink_ms(slow_blink_ms), .fast_blink_ms(fast_blink_ms),
    .led_on(led_on), .pause_toggle_sent(pause_toggle_sent),
    .command_valid(command_valid), .command_code(command_code),
    .session_state(session_state)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= poll_valid;
    end
    if (step) begin
      out_data <= {1'b0, session_state, command_code, command_valid,
                   pause_toggle_sent, led_on};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

FILE: test/bsc_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the button session controller: watches the poll and result streams
// and the configuration port, predicts each result and compares it field by field.
// Depends on bsc_pkg for widths, register indexes, register defaults and command codes.
module bsc_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // Fields from bit 0: time_ms[31:0], start_level, create_level, finish_level, zero pad.
  input  logic [bsc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: led_on, pause_toggle_sent, command_valid, command_code[1:0],
  // session_state[1:0], zero pad.
  input  logic [bsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              checked,
  output int                              n_start,
  output int                              n_segment,
  output int                              n_quit,
  output int                              n_pause
);

  typedef enum logic [1:0] {
    SESS_IDLE,
    SESS_RECORDING,
    SESS_CREATED,
    SESS_FINISHED
  } session_t;

  // One result transaction, laid out as on the master side (led_on in bit 0).
  typedef struct packed {
    logic       pad;
    session_t   session;
    logic [1:0] code;
    logic       cmd_valid;
    logic       pause;
    logic       led;
  } poll_result_t;

  localparam int SW_START  = 0;
  localparam int SW_CREATE = 1;
  localparam int SW_FINISH = 2;
  localparam int REPORT_LIMIT = 60;

  // Register copies.
  logic [bsc_pkg::MS16_W-1:0] debounce_ms, long_press_ms, slow_blink_ms, fast_blink_ms;
  logic [bsc_pkg::HOLD_W-1:0] holdoff_ms;

  // Debounce state per button.
  logic [2:0]                    settled, last_raw, long_done;
  logic [bsc_pkg::TIME_MS_W-1:0] change_at  [3];
  logic [bsc_pkg::TIME_MS_W-1:0] pressed_at [3];

  // Session state.
  session_t                      session;
  logic                          blink_level, led, fast, restart_ok;
  logic [bsc_pkg::TIME_MS_W-1:0] toggle_at, segment_at;

  poll_result_t expected_results [$];

  task automatic reset_model();
    debounce_ms   = bsc_pkg::DEBOUNCE_DEF;
    long_press_ms = bsc_pkg::LONG_PRESS_DEF;
    holdoff_ms    = bsc_pkg::HOLDOFF_DEF;
    slow_blink_ms = bsc_pkg::SLOW_BLINK_DEF;
    fast_blink_ms = bsc_pkg::FAST_BLINK_DEF;
    settled       = 3'b111;
    last_raw      = 3'b111;
    long_done     = 3'b000;
    for (int b = 0; b < 3; b++) begin
      change_at[b]  = '0;
      pressed_at[b] = '0;
    end
    session     = SESS_IDLE;
    blink_level = 1'b0;
    led         = 1'b0;
    fast        = 1'b0;
    restart_ok  = 1'b0;
    toggle_at   = '0;
    segment_at  = '0;
  endtask

  // Debounces one button for one poll and returns {long press, short press}.
  function automatic logic [1:0] debounce_button(int b, logic [bsc_pkg::TIME_MS_W-1:0] now,
                                                 logic raw);
    logic short_ev, long_ev;
    short_ev = 1'b0;
    long_ev  = 1'b0;
    if (raw != last_raw[b]) change_at[b] = now;
    if (now - change_at[b] > debounce_ms) begin
      if (raw != settled[b]) begin
        settled[b] = raw;
        if (!raw) begin
          pressed_at[b] = now;
          long_done[b]  = 1'b0;
        end else if (!long_done[b]) begin
          short_ev = 1'b1;
        end
      end
      if (!settled[b] && !long_done[b] && now - pressed_at[b] > long_press_ms) begin
        long_ev      = 1'b1;
        long_done[b] = 1'b1;
      end
    end
    last_raw[b] = raw;
    return {long_ev, short_ev};
  endfunction

  // Advances the session by one poll and returns the result it should produce.
  function automatic poll_result_t predict_poll(logic [bsc_pkg::TIME_MS_W-1:0] now,
                                                logic [2:0] raw);
    logic [1:0]                 ev_start, ev_create, ev_finish;
    logic                       start_short;
    logic [bsc_pkg::MS16_W-1:0] interval;
    poll_result_t               res;
    res       = '0;
    ev_start  = debounce_button(SW_START, now, raw[SW_START]);
    ev_create = debounce_button(SW_CREATE, now, raw[SW_CREATE]);
    ev_finish = debounce_button(SW_FINISH, now, raw[SW_FINISH]);
    start_short = ev_start[0];

    // A long start press while recording toggles pause and swallows the short press.
    if (ev_start[1] && session == SESS_RECORDING) begin
      fast        = ~fast;
      res.pause   = 1'b1;
      start_short = 1'b0;
    end

    case (session)
      SESS_IDLE: begin
        led = 1'b1;
        if (start_short) begin
          session       = SESS_RECORDING;
          res.cmd_valid = 1'b1;
          res.code      = bsc_pkg::CMD_START;
        end
      end
      SESS_RECORDING: begin
        interval = fast ? fast_blink_ms : slow_blink_ms;
        if (now - toggle_at > interval) begin
          blink_level = ~blink_level;
          led         = blink_level;
          toggle_at   = now;
        end
        if (ev_finish[0]) begin
          session       = SESS_FINISHED;
          res.cmd_valid = 1'b1;
          res.code      = bsc_pkg::CMD_QUIT;
        end else if (ev_create[0]) begin
          session       = SESS_CREATED;
          res.cmd_valid = 1'b1;
          res.code      = bsc_pkg::CMD_SEGMENT;
          segment_at    = now;
        end
      end
      SESS_CREATED: begin
        led  = 1'b1;
        fast = 1'b0;
        if (!restart_ok && now - segment_at > holdoff_ms) restart_ok = 1'b1;
        if (ev_finish[0]) begin
          session       = SESS_FINISHED;
          res.cmd_valid = 1'b1;
          res.code      = bsc_pkg::CMD_QUIT;
        end else if (start_short && restart_ok) begin
          session       = SESS_RECORDING;
          restart_ok    = 1'b0;
          res.cmd_valid = 1'b1;
          res.code      = bsc_pkg::CMD_START;
        end
      end
      default: led = 1'b0;
    endcase

    res.led     = led;
    res.session = session;
    return res;
  endfunction

  task automatic report_mismatch(string field, int want, int got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
  endtask

  task automatic compare_result(poll_result_t want, poll_result_t got);
    if (got.led !== want.led) report_mismatch("led_on", want.led, got.led);
    if (got.pause !== want.pause) report_mismatch("pause_toggle_sent", want.pause, got.pause);
    if (got.cmd_valid !== want.cmd_valid)
      report_mismatch("command_valid", want.cmd_valid, got.cmd_valid);
    if (got.code !== want.code) report_mismatch("command_code", want.code, got.code);
    if (got.session !== want.session)
      report_mismatch("session_state", want.session, got.session);
    if (got.pad !== want.pad) report_mismatch("tdata pad", want.pad, got.pad);
  endtask

  // Register writes, result checks and predictions, all sampled at the clock edge.
  always @(posedge clk) begin : monitor
    poll_result_t want, got;
    if (rst) begin
      reset_model();
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bsc_pkg::REG_DEBOUNCE:   debounce_ms   = cfg_data[bsc_pkg::MS16_W-1:0];
          bsc_pkg::REG_LONG_PRESS: long_press_ms = cfg_data[bsc_pkg::MS16_W-1:0];
          bsc_pkg::REG_HOLDOFF:    holdoff_ms    = cfg_data[bsc_pkg::HOLD_W-1:0];
          bsc_pkg::REG_SLOW_BLINK: slow_blink_ms = cfg_data[bsc_pkg::MS16_W-1:0];
          bsc_pkg::REG_FAST_BLINK: fast_blink_ms = cfg_data[bsc_pkg::MS16_W-1:0];
          default: ;
        endcase
      end

      // A result transaction is matched against the oldest prediction.
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        checked++;
        if (expected_results.size() == 0) begin
          fail_count++;
          $error("result transaction with no poll waiting, tdata %0h", m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          compare_result(want, got);
        end
      end

      // Each accepted poll transaction yields exactly one prediction.
      if (s_axis_tvalid && s_axis_tready) begin
        want = predict_poll(s_axis_tdata[bsc_pkg::TIME_MS_W-1:0],
                            s_axis_tdata[bsc_pkg::TIME_MS_W+2:bsc_pkg::TIME_MS_W]);
        expected_results.push_back(want);
        if (want.pause) n_pause++;
        if (want.cmd_valid) begin
          case (want.code)
            bsc_pkg::CMD_START:   n_start++;
            bsc_pkg::CMD_SEGMENT: n_segment++;
            bsc_pkg::CMD_QUIT:    n_quit++;
            default: ;
          endcase
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench top for the button session controller: clock, reset, poll stimulus,
// result back-pressure, register programming and the verdict.
// Depends on bsc_pkg, button_session_controller_top and bsc_checker.
module tb;

  localparam int RX_HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES  = 6;
  localparam int STUCK_LIMIT    = 3000;
  localparam int PHASE_ITEMS    = 310;
  localparam int FINISH_BIT     = 2;
  localparam logic [bsc_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [bsc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [bsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_we = 1'b0;
  logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int fail_count, pending, checked, n_start, n_segment, n_quit, n_pause;

  // Stimulus control shared with the receiver process.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit no_idle = 1'b0;
  int hold_requests = 0;
  int holds_done = 0;
  int stuck_cycles = 0;
  int settings_used = 0;

  // Button gesture generator state.
  logic [bsc_pkg::TIME_MS_W-1:0] now_ms = '0;
  logic [2:0]                    btn_target = 3'b111;
  int                            btn_hold_ms [3];
  logic                          last_finish = 1'b1;
  int                            cur_deb = 0;
  int                            cur_lng = 0;

  button_session_controller_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  bsc_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked),
    .n_start       (n_start),
    .n_segment     (n_segment),
    .n_quit        (n_quit),
    .n_pause       (n_pause)
  );

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: ends the run when no transaction completes for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stall bursts, plus a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done = holds_done + 1;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
      end else if (!no_idle && $urandom_range(99) < rx_idle_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(6)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offers one poll, after an optional idle burst, and waits for its transaction.
  task automatic send_poll(input logic [bsc_pkg::TIME_MS_W-1:0] t, input logic s,
                           input logic c, input logic f);
    if (!no_idle && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, f, c, s, t};
    do @(posedge clk); while (!s_axis_tready);
    last_finish = f;
  endtask

  // Stops offering polls until every predicted result has been checked.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bsc_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Writes all registers; the 16-bit ones get junk in the unused upper bits, and
  // a write to an unused index follows to show it has no effect.
  task automatic program_regs(input int deb, input int lng, input int hold, input int slow,
                              input int fast);
    logic [3:0] junk;
    cur_deb = deb;
    cur_lng = lng;
    junk = 4'($urandom_range(15));
    write_reg(bsc_pkg::REG_DEBOUNCE, {junk, deb[15:0]});
    junk = 4'($urandom_range(15));
    write_reg(bsc_pkg::REG_LONG_PRESS, {junk, lng[15:0]});
    write_reg(bsc_pkg::REG_HOLDOFF, hold[19:0]);
    junk = 4'($urandom_range(15));
    write_reg(bsc_pkg::REG_SLOW_BLINK, {junk, slow[15:0]});
    junk = 4'($urandom_range(15));
    write_reg(bsc_pkg::REG_FAST_BLINK, {junk, fast[15:0]});
    write_reg(REG_UNUSED_FIRST + 3'($urandom_range(2)), bsc_pkg::CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Starts the next press or release of one button, held long enough to pass debounce.
  task automatic next_gesture(input int b, input int s_hi);
    if (btn_target[b]) begin
      btn_target[b]  = 1'b0;
      btn_hold_ms[b] = cur_deb + s_hi + 1 + $urandom_range(2 * cur_lng + 2 * s_hi);
    end else begin
      btn_target[b]  = 1'b1;
      btn_hold_ms[b] = cur_deb + s_hi + 1 +
                       $urandom_range(3 * cur_deb + 4 * s_hi + cur_lng / 2);
    end
  endtask

  // Random polls: mostly real presses with bounce, some polls of pure noise. The finish
  // button only glitches for single polls unless finishing is allowed.
  task automatic run_random(input int n_items, input int s_lo, input int s_hi,
                            input bit allow_finish);
    int         k, b, step;
    logic [2:0] lv;
    for (b = 0; b < 3; b++) btn_hold_ms[b] = 0;
    for (k = 0; k < n_items; k++) begin
      if (k % 90 == 0) begin
        tx_idle_pct = 15 * $urandom_range(2);
        rx_idle_pct = 15 * $urandom_range(2);
      end
      if (k == 60) hold_requests++;
      if (k == n_items / 2) drain_results();
      if ($urandom_range(39) == 0) begin
        now_ms = $urandom;
        lv = 3'($urandom_range(7));
      end else begin
        step = $urandom_range(s_hi, s_lo);
        now_ms = now_ms + step;
        for (b = 0; b < 3; b++) begin
          btn_hold_ms[b] -= step;
          if (btn_hold_ms[b] <= 0 && (b != FINISH_BIT || allow_finish)) next_gesture(b, s_hi);
        end
        lv = btn_target;
        for (b = 0; b < FINISH_BIT; b++)
          if ($urandom_range(11) == 0) lv[b] = ~lv[b];
        if ($urandom_range(15) == 0) lv[FINISH_BIT] = 1'b0;
      end
      if (!last_finish && !allow_finish) lv[FINISH_BIT] = 1'b1;
      send_poll(now_ms, lv[0], lv[1], lv[2]);
    end
    drain_results();
  endtask

  // Holds one set of levels {finish, create, start} for n polls, 1 ms apart.
  task automatic hold_levels(input logic [2:0] lv, input int n);
    repeat (n) begin
      now_ms = now_ms + 1;
      send_poll(now_ms, lv[0], lv[1], lv[2]);
    end
  endtask

  // Main sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: tiny limits so each gesture takes only a few polls.
    program_regs(2, 10, 20, 3, 1);
    send_poll(0, 1, 1, 1);
    // Long start press while idle is ignored and gives no short press on release.
    send_poll(1, 0, 1, 1);
    send_poll(4, 0, 1, 1);
    send_poll(15, 0, 1, 1);
    send_poll(16, 1, 1, 1);
    send_poll(19, 1, 1, 1);
    // Short start press starts recording.
    send_poll(20, 0, 1, 1);
    send_poll(23, 0, 1, 1);
    send_poll(24, 1, 1, 1);
    send_poll(27, 1, 1, 1);
    // A one-poll finish glitch never gets through debounce.
    send_poll(28, 1, 1, 0);
    send_poll(29, 1, 1, 1);
    // Short create press makes a new segment.
    send_poll(30, 1, 0, 1);
    send_poll(33, 1, 0, 1);
    send_poll(34, 1, 1, 1);
    send_poll(37, 1, 1, 1);
    // Start within the restart hold-off is refused, later it is accepted.
    send_poll(38, 0, 1, 1);
    send_poll(41, 0, 1, 1);
    send_poll(42, 1, 1, 1);
    send_poll(45, 1, 1, 1);
    send_poll(60, 0, 1, 1);
    send_poll(63, 0, 1, 1);
    send_poll(64, 1, 1, 1);
    send_poll(67, 1, 1, 1);
    // Long start press while recording toggles pause and fast blink.
    send_poll(68, 0, 1, 1);
    send_poll(71, 0, 1, 1);
    send_poll(82, 0, 1, 1);
    send_poll(83, 1, 1, 1);
    send_poll(86, 1, 1, 1);
    // Timestamp extremes and wrap-around.
    send_poll(32'hFFFF_FFFF, 1, 1, 1);
    send_poll(0, 1, 1, 1);
    drain_results();

    // Random phases over several register settings.
    program_regs(bsc_pkg::DEBOUNCE_DEF, bsc_pkg::LONG_PRESS_DEF, bsc_pkg::HOLDOFF_DEF,
                 bsc_pkg::SLOW_BLINK_DEF, bsc_pkg::FAST_BLINK_DEF);
    run_random(PHASE_ITEMS, 5, 40, 1'b0);
    program_regs(0, 0, 0, 0, 0);
    run_random(PHASE_ITEMS, 0, 3, 1'b0);
    program_regs(65535, 65535, 1000000, 65535, 65535);
    run_random(PHASE_ITEMS, 2000, 20000, 1'b0);
    program_regs($urandom_range(50), $urandom_range(300, 1), $urandom_range(3000),
                 $urandom_range(200), $urandom_range(100));
    run_random(PHASE_ITEMS, 1, 30, 1'b0);
    now_ms = 32'hFFFF_FFFF - $urandom_range(2000);
    program_regs($urandom_range(20), $urandom_range(200, 1), $urandom_range(500),
                 $urandom_range(100), $urandom_range(50));
    run_random(PHASE_ITEMS, 1, 30, 1'b0);

    // Closing part, without idling: start, then quit with create pressed alongside
    // finish, then polls in the finished state.
    program_regs(2, 10, 0, 3, 1);
    no_idle = 1'b1;
    hold_levels(3'b111, 5);
    hold_levels(3'b110, 5);
    hold_levels(3'b111, 5);
    hold_levels(3'b001, 5);
    hold_levels(3'b111, 5);
    btn_target = 3'b111;
    run_random(40, 1, 3, 1'b1);

    $display("Summary: %0d polls checked over %0d register settings, from all-zero to max.",
             checked, settings_used);
    $display("Summary: %0d start, %0d new-segment, %0d quit commands, %0d pause toggles.",
             n_start, n_segment, n_quit, n_pause);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
design/bsc_pkg.sv
design/bsc_button.sv
design/bsc_session.sv
design/button_session_controller_top.sv
test/bsc_checker.sv
test/tb.sv
